@@ design/pnct_pkg.sv @@
// ---------------------------------------------------------------------------
// Pixel node cover test package
// Shared types, codes and fixed-point constants of the cover test block.
// ---------------------------------------------------------------------------
package pnct_pkg;

    localparam int MAX_RAYS_DEF  = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIMS          = 4;

    typedef logic signed [31:0] q_t;

    localparam q_t Q_MAX = 32'sh7fffffff;
    localparam q_t Q_MIN = 32'sh80000000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef enum logic [2:0] {
        CFG_EXTENT_X  = 3'd0,
        CFG_EXTENT_Y  = 3'd1,
        CFG_EXTENT_Z  = 3'd2,
        CFG_EXTENT_W  = 3'd3,
        CFG_RAY_COUNT = 3'd4
    } cfg_index_t;

endpackage

@@ design/pnct_div_lane.sv @@
// ---------------------------------------------------------------------------
// Pixel node cover test slab division lane
// Pipelined restoring divider that turns one slab numerator and one ray
// direction into a saturated Q16.16 ray parameter, one bit per stage.
// ---------------------------------------------------------------------------
module pnct_div_lane
    import pnct_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] num,
    input  q_t                 dir,
    output q_t                 t
);

    localparam int QW = 33 + FRAC_BITS;
    localparam int RW = 32 + QW;

    logic signed [32:0] num0_reg;
    q_t                 dir0_reg;

    logic [RW-1:0] rq_reg   [QW+1];
    logic [31:0]   den_reg  [QW+1];
    logic          neg_reg  [QW+1];
    logic          dz_reg   [QW+1];
    logic          npos_reg [QW+1];

    logic [32:0] mag;
    logic [31:0] dmag;
    q_t          t_reg;

    always_comb
    begin
        mag  = num0_reg[32] ? 33'(-num0_reg) : 33'(num0_reg);
        dmag = dir0_reg[31] ? 32'(-dir0_reg) : 32'(dir0_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num0_reg    <= num;
            dir0_reg    <= dir;
            rq_reg[0]   <= {32'd0, mag, {FRAC_BITS{1'b0}}};
            den_reg[0]  <= dmag;
            neg_reg[0]  <= num0_reg[32] ^ dir0_reg[31];
            dz_reg[0]   <= (dir0_reg == 32'sd0);
            npos_reg[0] <= !num0_reg[32] && (num0_reg != 33'sd0);
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [32:0]   top;
        logic [32:0]   diff;
        logic [RW-1:0] rq_next;

        always_comb
        begin
            top  = {1'b0, rq_reg[k-1][RW-2:QW-1]};
            diff = top - {1'b0, den_reg[k-1]};
            if (!diff[32])
            begin
                rq_next = {diff[31:0], rq_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                rq_next = {top[31:0], rq_reg[k-1][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rq_reg[k]   <= rq_next;
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                dz_reg[k]   <= dz_reg[k-1];
                npos_reg[k] <= npos_reg[k-1];
            end
        end
    end

    logic [QW-1:0] quo;
    q_t            t_next;

    always_comb
    begin
        quo = rq_reg[QW][QW-1:0];
        if (dz_reg[QW])
        begin
            t_next = npos_reg[QW] ? Q_MAX : Q_MIN;
        end
        else if (!neg_reg[QW])
        begin
            t_next = (quo > {{(QW-32){1'b0}}, 32'h7fffffff}) ? Q_MAX : q_t'(quo[31:0]);
        end
        else
        begin
            t_next = (quo > {{(QW-32){1'b0}}, 32'h80000000}) ? Q_MIN : q_t'(-quo[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= t_next;
        end
    end

    assign t = t_reg;

endmodule

@@ design/pixel_node_cover_test_4d.sv @@
// ---------------------------------------------------------------------------
// Pixel node cover test over x, y, z and time
// Stores reflected corner rays and tests 4D node boxes against ray_count of them.
// ---------------------------------------------------------------------------
// The input channel carries load and test items. A load reflects one corner
// ray and writes it into its slot at the transfer edge and gives no result.
// A test issues n stored rays, one per cycle while the pipeline is not
// stalled, into eight pipelined division lanes (four axes, entry and exit),
// where n is ray_count taken as one when zero and as MAX_RAYS when larger;
// the input takes the next item along with the test's last ray. The slab
// dividers give one quotient bit per stage.
// Tests and loads may follow each other without gaps; a load after a test
// never affects that test.
// Results leave through an output register. When the receiver stalls, the
// pipeline keeps moving until a finished result reaches the final stage;
// only then it holds, and the input stops taking items.
// Reset clears all control state, sets every extent to zero and ray_count to
// four. Stored rays are undefined until loaded. Configuration writes through
// cfg_write, cfg_index and cfg_data take effect at the next edge.
// ---------------------------------------------------------------------------
module pixel_node_cover_test_4d
    import pnct_pkg::*;
#(
    parameter int MAX_RAYS  = MAX_RAYS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [1:0]  ray_slot,
    input  q_t          lo_x,
    input  q_t          lo_y,
    input  q_t          lo_z,
    input  q_t          lo_w,
    input  q_t          hi_x,
    input  q_t          hi_y,
    input  q_t          hi_z,
    input  q_t          hi_w,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        node_covered
);

    localparam int CW = (MAX_RAYS > 1) ? $clog2(MAX_RAYS) : 1;
    localparam int L  = 33 + FRAC_BITS + 3;

    q_t lo_in [DIMS];
    q_t hi_in [DIMS];

    assign lo_in[0] = lo_x;
    assign lo_in[1] = lo_y;
    assign lo_in[2] = lo_z;
    assign lo_in[3] = lo_w;
    assign hi_in[0] = hi_x;
    assign hi_in[1] = hi_y;
    assign hi_in[2] = hi_z;
    assign hi_in[3] = hi_w;

    logic [30:0] ext_reg [DIMS];
    logic [2:0]  ray_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < DIMS; a++)
            begin
                ext_reg[a] <= 31'd0;
            end
            ray_count_reg <= 3'd4;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EXTENT_X:  ext_reg[0] <= cfg_data;
                CFG_EXTENT_Y:  ext_reg[1] <= cfg_data;
                CFG_EXTENT_Z:  ext_reg[2] <= cfg_data;
                CFG_EXTENT_W:  ext_reg[3] <= cfg_data;
                CFG_RAY_COUNT: ray_count_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic accept;

    logic          iss_valid_reg;
    logic [CW-1:0] iss_cnt_reg;
    logic [CW-1:0] iss_last_reg;
    q_t            iss_lo_reg [DIMS];
    q_t            iss_hi_reg [DIMS];
    logic [CW-1:0] last_n;

    assign in_ready = en && (!iss_valid_reg || (iss_cnt_reg == iss_last_reg));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (ray_count_reg == 3'd0)
        begin
            last_n = '0;
        end
        else if (32'(ray_count_reg) > MAX_RAYS)
        begin
            last_n = CW'(MAX_RAYS - 1);
        end
        else
        begin
            last_n = CW'(32'(ray_count_reg) - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_valid_reg <= 1'b0;
            iss_cnt_reg   <= '0;
            iss_last_reg  <= '0;
        end
        else if (en)
        begin
            if (iss_valid_reg)
            begin
                if (iss_cnt_reg == iss_last_reg)
                begin
                    iss_valid_reg <= 1'b0;
                end
                else
                begin
                    iss_cnt_reg <= iss_cnt_reg + 1'b1;
                end
            end
            if (accept && command == CMD_TEST)
            begin
                iss_valid_reg <= 1'b1;
                iss_cnt_reg   <= '0;
                iss_last_reg  <= last_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_TEST)
        begin
            iss_lo_reg <= lo_in;
            iss_hi_reg <= hi_in;
        end
    end

    q_t            org_w [DIMS];
    q_t            dir_w [DIMS];
    logic          wr_ok;
    logic [CW-1:0] wr_idx;

    assign wr_ok  = 32'(ray_slot) < MAX_RAYS;
    assign wr_idx = CW'(ray_slot);

    always_comb
    begin
        logic               flip;
        logic signed [32:0] diff;
        for (int a = 0; a < DIMS; a++)
        begin
            flip = (a == 2) ? (hi_in[a] > 32'sd0) : hi_in[a][31];
            diff = $signed({2'b00, ext_reg[a]}) - {lo_in[a][31], lo_in[a]};
            if (!flip)
            begin
                org_w[a] = lo_in[a];
                dir_w[a] = hi_in[a];
            end
            else
            begin
                if (!diff[32] && diff[31])
                begin
                    org_w[a] = Q_MAX;
                end
                else if (diff[32] && !diff[31])
                begin
                    org_w[a] = Q_MIN;
                end
                else
                begin
                    org_w[a] = diff[31:0];
                end
                dir_w[a] = (hi_in[a] == Q_MIN) ? Q_MAX : q_t'(-hi_in[a]);
            end
        end
    end

    q_t org_mem [MAX_RAYS][DIMS];
    q_t dir_mem [MAX_RAYS][DIMS];

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_LOAD && wr_ok)
        begin
            org_mem[wr_idx] <= org_w;
            dir_mem[wr_idx] <= dir_w;
        end
    end

    logic rv_reg;
    logic rf_reg;
    logic rl_reg;
    q_t   rd_org_reg [DIMS];
    q_t   rd_dir_reg [DIMS];
    q_t   rd_lo_reg  [DIMS];
    q_t   rd_hi_reg  [DIMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
            rf_reg <= 1'b0;
            rl_reg <= 1'b0;
        end
        else if (en)
        begin
            rv_reg <= iss_valid_reg;
            rf_reg <= (iss_cnt_reg == '0);
            rl_reg <= (iss_cnt_reg == iss_last_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_org_reg <= org_mem[iss_cnt_reg];
            rd_dir_reg <= dir_mem[iss_cnt_reg];
            rd_lo_reg  <= iss_lo_reg;
            rd_hi_reg  <= iss_hi_reg;
        end
    end

    q_t t_lane [2*DIMS];

    for (genvar a = 0; a < DIMS; a++)
    begin : g_axis
        logic signed [32:0] num_lo;
        logic signed [32:0] num_hi;

        assign num_lo = {rd_lo_reg[a][31], rd_lo_reg[a]} - {rd_org_reg[a][31], rd_org_reg[a]};
        assign num_hi = {rd_hi_reg[a][31], rd_hi_reg[a]} - {rd_org_reg[a][31], rd_org_reg[a]};

        pnct_div_lane #(.FRAC_BITS(FRAC_BITS)) u_enter
        (
            .clk (clk),
            .en  (en),
            .num (num_lo),
            .dir (rd_dir_reg[a]),
            .t   (t_lane[2*a])
        );

        pnct_div_lane #(.FRAC_BITS(FRAC_BITS)) u_exit
        (
            .clk (clk),
            .en  (en),
            .num (num_hi),
            .dir (rd_dir_reg[a]),
            .t   (t_lane[2*a+1])
        );
    end

    logic [L-1:0] pv_reg;
    logic [L-1:0] pf_reg;
    logic [L-1:0] pl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
            pf_reg <= '0;
            pl_reg <= '0;
        end
        else if (en)
        begin
            pv_reg <= {pv_reg[L-2:0], rv_reg};
            pf_reg <= {pf_reg[L-2:0], rf_reg};
            pl_reg <= {pl_reg[L-2:0], rl_reg};
        end
    end

    q_t ent;
    q_t lv;

    always_comb
    begin
        ent = t_lane[0];
        lv  = t_lane[1];
        for (int a = 1; a < DIMS; a++)
        begin
            if (t_lane[2*a] > ent)
            begin
                ent = t_lane[2*a];
            end
            if (t_lane[2*a+1] < lv)
            begin
                lv = t_lane[2*a+1];
            end
        end
    end

    logic a_v_reg;
    logic a_first_reg;
    logic a_last_reg;
    q_t   a_ent_reg;
    q_t   a_lv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg     <= 1'b0;
            a_first_reg <= 1'b0;
            a_last_reg  <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg     <= pv_reg[L-1];
            a_first_reg <= pf_reg[L-1];
            a_last_reg  <= pl_reg[L-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ent_reg <= ent;
            a_lv_reg  <= lv;
        end
    end

    logic acc_reg;
    logic cov_next;
    logic out_valid_reg;
    logic node_covered_reg;

    assign en       = !(out_valid_reg && !out_ready && a_v_reg && a_last_reg);
    assign cov_next = (a_first_reg ? 1'b1 : acc_reg) & (a_ent_reg < a_lv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            node_covered_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (en && a_v_reg)
            begin
                acc_reg <= cov_next;
                if (a_last_reg)
                begin
                    out_valid_reg    <= 1'b1;
                    node_covered_reg <= cov_next;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign node_covered = node_covered_reg;

`ifndef ASSERT_OFF
    a_no_accept_mid_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_valid_reg && (iss_cnt_reg != iss_last_reg)) |-> !in_ready)
        else $error("input taken while a test is still issuing rays");

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        iss_valid_reg |-> (iss_cnt_reg <= iss_last_reg))
        else $error("ray counter passed the last ray");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(a_v_reg && a_last_reg))
        else $error("result raised without a last ray in the final stage");
`endif

endmodule
